### rtl/bra_pkg.sv
// Package for the bitmap range allocator: sizes, codes, request and result types.
// No dependencies.
`timescale 1ns / 1ps
package bra_pkg;
  localparam int unsigned Capacity  = 4096;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned Words     = Capacity / WordBits;
  localparam int unsigned AddrW     = $clog2(Words);
  localparam int unsigned BitW      = $clog2(WordBits);
  localparam int unsigned LenW      = 13;
  localparam int unsigned IdxW      = 12;

  typedef enum logic [1:0] {
    ActFill  = 2'd0,
    ActClear = 2'd1,
    ActFind  = 2'd2,
    ActCheck = 2'd3
  } action_e;

  typedef struct packed {
    action_e          action;
    logic [IdxW-1:0]  first_index;
    logic [LenW-1:0]  run_length;
    logic             bit_value;
  } req_t;

  typedef struct packed {
    logic             success;
    logic [IdxW-1:0]  found_index;
  } rsp_t;

  typedef enum logic [1:0] {
    StIdle = 2'd0,
    StRead = 2'd1,
    StWork = 2'd2,
    StDone = 2'd3
  } state_e;
endpackage

### rtl/bra_store.sv
// Bit store memory of the bitmap range allocator, with a clearing pass after reset.
// Depends on bra_pkg.
`timescale 1ns / 1ps
module bra_store import bra_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_i,
  output logic [WordBits-1:0] rdata_o,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  logic [WordBits-1:0] wdata_i,
  output logic                ready_o
);
  logic [WordBits-1:0] mem [Words];
  logic [AddrW:0]      clr_q;

  assign ready_o = clr_q[AddrW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (!clr_q[AddrW]) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!clr_q[AddrW]) begin
      mem[clr_q[AddrW-1:0]] <= '0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

### rtl/bitmap_range_allocator.sv
// Top level of the bitmap range allocator: configuration port and the word-walking sequencer.
// Depends on bra_pkg and bra_store.
`timescale 1ns / 1ps
// The block keeps a 4096-bit store in a 128 x 32 memory and serves one request at a
// time. A request is taken when start_i is high and busy_o is low; exactly one result
// follows, shown for one cycle with done_o high, and the receiver cannot stall it.
// The sequencer walks the store one word per memory access: each word is read in StRead
// and then modified and written back, or scanned, in StWork in the next cycle.
// Fill and clear touch only the words of the clipped range; check walks the range
// and stops at the first mismatch; find walks from word 0 until the run is complete or
// the region ends. After reset a clearing pass zeroes the memory; busy_o stays high
// during it, while register writes are taken as ever. region_length sits at byte
// address 0; values above 4096 act as 4096.
module bitmap_range_allocator import bra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  req_t        req_i,
  output logic        busy_o,
  output logic        done_o,
  output rsp_t        rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic [2:0] AddrRegion = 3'd0;

  logic [LenW-1:0] region_q;
  assign pready = 1'b1;
  assign prdata = (paddr == AddrRegion) ? {{(32-LenW){1'b0}}, region_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q <= LenW'(Capacity);
    end else if (psel && penable && pwrite && paddr == AddrRegion) begin
      region_q <= pwdata[LenW-1:0];
    end
  end

  // Region length clipped to the capacity.
  logic [LenW-1:0] len;
  assign len = (region_q > LenW'(Capacity)) ? LenW'(Capacity) : region_q;

  state_e          state_q, state_d;
  req_t            req_q;
  logic [LenW:0]   lo_q, hi_q;       // bit range [lo, hi) being walked
  logic [AddrW:0]  word_q, word_d;   // current word, one extra bit for the end
  logic [LenW-1:0] run_q, run_d;     // length of the current run of matching bits
  logic            ok_q, ok_d;
  logic            done_q, done_d;
  rsp_t            rsp_q, rsp_d;

  logic                re, we, mem_ready;
  logic [WordBits-1:0] rdata, wdata;

  bra_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (re),
    .raddr_i (word_q[AddrW-1:0]),
    .rdata_o (rdata),
    .we_i    (we),
    .waddr_i (word_q[AddrW-1:0]),
    .wdata_i (wdata),
    .ready_o (mem_ready)
  );

  assign busy_o = (state_q != StIdle) || !mem_ready;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Request decode at acceptance.
  logic [LenW:0] end_full, end_clip;
  assign end_full = {2'b00, req_i.first_index} + {1'b0, req_i.run_length};
  assign end_clip = (end_full > {1'b0, len}) ? {1'b0, len} : end_full;

  // Per-word mask of bits inside [lo, hi).
  logic [WordBits-1:0] mask, match;
  logic [LenW:0]       wbase;
  always_comb begin
    wbase = {1'b0, word_q, {BitW{1'b0}}};
    for (int b = 0; b < WordBits; b++) begin
      mask[b] = ((wbase + (LenW+1)'(b)) >= lo_q) && ((wbase + (LenW+1)'(b)) < hi_q);
    end
    match = req_q.bit_value ? rdata : ~rdata;
  end

  // Find: for every bit of the word, the length of the run of matching bits that ends
  // there. A run that fills the word up to that bit continues the run carried over from
  // earlier words. The lowest bit whose run reaches the wanted length completes the find.
  logic [WordBits-1:0] seek, hit_vec;
  logic [BitW:0]       tail [WordBits];
  logic [LenW-1:0]     run_at [WordBits];
  logic [BitW-1:0]     hit_pos;
  logic [LenW-1:0]     scan_run, scan_hit_start;
  logic                scan_hit;
  always_comb begin
    seek = match & mask;
    for (int b = 0; b < WordBits; b++) begin
      tail[b] = (BitW+1)'(b + 1);
      for (int j = 0; j <= b; j++) begin
        if (!seek[j]) tail[b] = (BitW+1)'(b - j);
      end
      run_at[b]  = (tail[b] == (BitW+1)'(b + 1)) ? run_q + LenW'(b + 1) : LenW'(tail[b]);
      hit_vec[b] = (run_at[b] >= req_q.run_length);
    end
    hit_pos = '0;
    for (int b = WordBits - 1; b >= 0; b--) begin
      if (hit_vec[b]) hit_pos = BitW'(b);
    end
    scan_hit       = |hit_vec;
    scan_run       = run_at[WordBits-1];
    scan_hit_start = wbase[LenW-1:0] + LenW'(hit_pos) + LenW'(1) - req_q.run_length;
  end

  logic last_word;
  assign last_word = ({1'b0, word_q + 1'b1, {BitW{1'b0}}} >= hi_q);

  always_comb begin
    state_d  = state_q;
    word_d   = word_q;
    run_d    = run_q;
    ok_d     = ok_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    re       = 1'b0;
    we       = 1'b0;
    wdata    = (req_q.action == ActFill) ? (rdata | mask) : (rdata & ~mask);
    unique case (state_q)
      StIdle: ;
      StRead: begin
        re      = 1'b1;
        state_d = StWork;
      end
      StWork: begin
        priority case (req_q.action)
          ActFill, ActClear: we = 1'b1;
          ActCheck: if ((match & mask) != mask) ok_d = 1'b0;
          default: begin
            run_d = scan_run;
            if (scan_hit) begin
              ok_d              = 1'b1;
              rsp_d.found_index = scan_hit_start[IdxW-1:0];
            end
          end
        endcase
        if (last_word || !ok_d || (req_q.action == ActFind && scan_hit)) begin
          state_d = StDone;
        end else begin
          word_d  = word_q + 1'b1;
          state_d = StRead;
        end
      end
      StDone: begin
        done_d        = 1'b1;
        rsp_d.success = ok_q;
        if (!ok_q) rsp_d.found_index = '0;
        state_d       = StIdle;
      end
      default: state_d = StIdle;
    endcase
    if (state_q == StWork && req_q.action == ActFind && !scan_hit) begin
      ok_d = 1'b0;
      if (!last_word) ok_d = 1'b1;
    end
  end

  // Decisions at acceptance that need no memory walk.
  logic           imm;
  logic           imm_ok;
  logic [LenW:0]  lo_n, hi_n;
  always_comb begin
    lo_n   = {1'b0, 1'b0, req_i.first_index};
    hi_n   = end_clip;
    imm    = 1'b0;
    imm_ok = 1'b1;
    unique case (req_i.action)
      ActFill, ActClear: imm = (lo_n >= hi_n);
      ActCheck: begin
        if (end_full > {1'b0, len}) begin
          imm = 1'b1; imm_ok = 1'b0;
        end else begin
          imm = (req_i.run_length == '0);
        end
      end
      default: begin
        lo_n = '0;
        hi_n = {1'b0, len};
        if (req_i.run_length == '0) begin
          imm = 1'b1;
        end else if (req_i.run_length > len) begin
          imm = 1'b1; imm_ok = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      done_q <= done_d;
      if (start_i && !busy_o) begin
        state_q <= imm ? StDone : StRead;
      end else begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q             <= req_i;
      lo_q              <= lo_n;
      hi_q              <= hi_n;
      word_q            <= lo_n[LenW-1:BitW];
      run_q             <= '0;
      ok_q              <= (req_i.action == ActFind) ? ~imm | imm_ok : imm_ok;
      rsp_q.found_index <= '0;
    end else begin
      word_q <= word_d;
      run_q  <= run_d;
      ok_q   <= ok_d;
      rsp_q  <= rsp_d;
    end
  end
endmodule

### test/tb_bitmap_range_allocator.sv
// Testbench for the bitmap range allocator: random and directed fill, clear, find and
// check requests against a bit-accurate predictor, with region_length changed over the run.
// Depends on bra_pkg and the bitmap_range_allocator RTL.
`timescale 1ns / 1ps
module tb_bitmap_range_allocator;
  import bra_pkg::*;

  // Region length after reset, and the largest value the 13-bit register holds.
  localparam int unsigned RegionReset = 4096;
  localparam int unsigned RegionMax   = 8191;
  // Quiet cycles after the last result of a phase before the region register changes.
  localparam int          DrainCycles = 400;
  localparam logic [2:0]  AddrRegion  = 3'd0;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  req_t        req_i;
  logic        busy_o;
  logic        done_o;
  rsp_t        rsp_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bitmap_range_allocator u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .rsp_o   (rsp_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Predictor state: its own copy of the bit store and of the region register.
  logic [Capacity-1:0] shadow_bits;
  int unsigned         shadow_region;

  // Requests waiting for the driver, and results the predictor has worked out.
  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   mismatch_count;
  bit   feed_done;

  // Works out the result of one request and applies its writes to the shadow store.
  function automatic rsp_t predict_request(req_t r);
    rsp_t        res;
    int unsigned len;
    int unsigned stop;
    int unsigned run;
    len = (shadow_region > Capacity) ? Capacity : shadow_region;
    res = '0;
    stop = r.first_index + r.run_length;
    case (r.action)
      ActFill, ActClear: begin
        if (stop > len) stop = len;
        for (int unsigned i = r.first_index; i < stop; i++)
          shadow_bits[i] = (r.action == ActFill);
        res.success = 1'b1;
      end
      ActFind: begin
        if (r.run_length == 0) begin
          res.success = 1'b1;
        end else if (r.run_length <= len) begin
          run = 0;
          for (int unsigned i = 0; i < len; i++) begin
            if (shadow_bits[i] == r.bit_value) begin
              run++;
              if (run == r.run_length) begin
                res.success = 1'b1;
                res.found_index = IdxW'(i + 1 - r.run_length);
                break;
              end
            end else begin
              run = 0;
            end
          end
        end
      end
      default: begin
        if (stop <= len) begin
          res.success = 1'b1;
          for (int unsigned i = r.first_index; i < stop; i++) begin
            if (shadow_bits[i] != r.bit_value) begin
              res.success = 1'b0;
              break;
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  // Driver: takes requests from the queue, waits a random gap before each, and holds
  // start_i until the request is taken at a rising edge. Prediction happens at
  // acceptance, so the shadow store follows the order in which the block sees them.
  int  gap_left;
  bit  holding;
  bit  taken;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (taken) begin
        taken   = 1'b0;
        holding = 1'b0;
      end
      if (!holding && pending_reqs.size() > 0) begin
        req_i   <= pending_reqs.pop_front();
        holding  = 1'b1;
        gap_left = $urandom_range(0, 4);
      end
      if (holding && gap_left == 0) begin
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
        if (holding) gap_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      expected_rsps.push_back(predict_request(req_i));
      taken = 1'b1;
    end
  end

  // Monitor: each done_o cycle carries one result, compared with the oldest prediction.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o) begin
      if (expected_rsps.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: success %0b index %0d", rsp_o.success,
                   rsp_o.found_index);
      end else begin
        want = expected_rsps.pop_front();
        if (rsp_o.success !== want.success || rsp_o.found_index !== want.found_index) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected success %0b index %0d, got %0b %0d",
                     want.success, want.found_index, rsp_o.success, rsp_o.found_index);
        end
      end
    end
  end

  // Writes region_length through the APB port: setup cycle, then access cycle.
  task automatic write_region(int unsigned value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrRegion;
    pwdata <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_region = value & RegionMax;
  endtask

  // Waits until every queued request has been answered and the block is quiet.
  task automatic drain_block();
    while (!(pending_reqs.size() == 0 && !holding && !start_i &&
             expected_rsps.size() == 0))
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic req_t make_req(action_e act, int unsigned first, int unsigned count,
                                    bit value);
    req_t r;
    r.action = act;
    r.first_index = IdxW'(first);
    r.run_length = LenW'(count);
    r.bit_value = value;
    return r;
  endfunction

  // Random request. Most ranges are short so that fills and clears build a fragmented
  // store that finds and checks can probe; a few span large parts of the region.
  function automatic req_t random_req(int unsigned region);
    int unsigned span;
    int unsigned count;
    int unsigned first;
    span = (region == 0) ? 1 : ((region > Capacity) ? Capacity : region);
    case ($urandom_range(0, 9))
      0: count = $urandom_range(0, 8191);
      1, 2: count = $urandom_range(0, 512);
      default: count = $urandom_range(0, 48);
    endcase
    if ($urandom_range(0, 7) == 0) first = $urandom_range(0, 4095);
    else first = $urandom_range(0, span - 1);
    return make_req(action_e'($urandom_range(0, 3)), first, count, 1'($urandom));
  endfunction

  initial begin
    int unsigned regions[6];
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    holding = 1'b0;
    taken = 1'b0;
    gap_left = 0;
    mismatch_count = 0;
    feed_done = 1'b0;
    shadow_bits = '0;
    shadow_region = RegionReset;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset region: extremes, every action, and the special cases.
    pending_reqs.push_back(make_req(ActFind, 0, 0, 1'b1));       // zero-length find
    pending_reqs.push_back(make_req(ActFind, 0, 4096, 1'b0));    // whole store is zero
    pending_reqs.push_back(make_req(ActFind, 0, 4097, 1'b0));    // longer than region
    pending_reqs.push_back(make_req(ActFill, 0, 0, 1'b0));       // empty write
    pending_reqs.push_back(make_req(ActFill, 32, 32, 1'b0));     // ends on a word edge
    pending_reqs.push_back(make_req(ActCheck, 32, 32, 1'b1));
    pending_reqs.push_back(make_req(ActCheck, 31, 2, 1'b1));
    pending_reqs.push_back(make_req(ActFind, 0, 33, 1'b1));
    pending_reqs.push_back(make_req(ActFind, 0, 32, 1'b1));
    pending_reqs.push_back(make_req(ActFill, 4000, 8191, 1'b1)); // clipped write
    pending_reqs.push_back(make_req(ActCheck, 4000, 96, 1'b1));
    pending_reqs.push_back(make_req(ActCheck, 4000, 97, 1'b1));  // check past region
    pending_reqs.push_back(make_req(ActCheck, 4095, 0, 1'b0));   // empty check
    pending_reqs.push_back(make_req(ActFind, 0, 96, 1'b1));      // start near the top
    pending_reqs.push_back(make_req(ActFind, 0, 1, 1'b1));
    pending_reqs.push_back(make_req(ActClear, 4095, 1, 1'b1));
    pending_reqs.push_back(make_req(ActFind, 0, 95, 1'b1));
    pending_reqs.push_back(make_req(ActClear, 0, 4096, 1'b0));
    pending_reqs.push_back(make_req(ActCheck, 0, 4096, 1'b0));
    pending_reqs.push_back(make_req(ActFill, 4095, 1, 1'b0));
    pending_reqs.push_back(make_req(ActFind, 0, 1, 1'b1));
    drain_block();

    // Random phases, each under its own region length, the extremes among them.
    regions = '{0, 1, 100, 4096, RegionMax, 0};
    for (int p = 0; p < 6; p++) begin
      regions[5] = $urandom_range(1, 4096);
      write_region(regions[p]);
      for (int n = 0; n < 340; n++) pending_reqs.push_back(random_req(shadow_region));
      drain_block();
    end
    feed_done = 1'b1;
  end

  initial begin
    wait (feed_done);
    if (mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Slowest run: about 2100 requests, plus gaps and drains.
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
